@@ src/luhn_pkg.sv @@
package luhn_pkg;

   localparam int CardWidth  = 54;
   localparam int BinWidth   = 56;
   localparam int BcdDigits  = 18;
   localparam int BcdWidth   = 4 * BcdDigits;
   localparam int ConvSteps  = BinWidth / 8;
   localparam int ScanSteps  = BcdDigits / 2;
   localparam int StepWidth  = 4;

   localparam logic [1:0] VERDICT_INVALID    = 2'd0;
   localparam logic [1:0] VERDICT_MASTERCARD = 2'd1;
   localparam logic [1:0] VERDICT_AMEX       = 2'd2;
   localparam logic [1:0] VERDICT_VISA       = 2'd3;

   typedef struct packed {
      logic load;
      logic convert;
      logic scan;
      logic finish;
   } luhn_cmd_type;

   typedef struct packed {
      logic out_free;
   } luhn_status_type;

endpackage

@@ src/luhn_ctrl.sv @@
module luhn_ctrl
   import luhn_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  luhn_status_type status,
   output luhn_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam logic [StepWidth-1:0] ConvLast = StepWidth'(ConvSteps - 1);
   localparam logic [StepWidth-1:0] ScanLast = StepWidth'(ScanSteps - 1);

   logic [1:0]           state_ff, state_in;
   logic [StepWidth-1:0] step_ff, step_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.convert = 1'b1;
            if (step_ff == ConvLast) begin
               step_in  = '0;
               state_in = ST_SCAN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (step_ff == ScanLast) begin
               step_in  = '0;
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

@@ src/luhn_datapath.sv @@
module luhn_datapath
   import luhn_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [CardWidth-1:0] card_number,
   input  luhn_cmd_type         cmd,
   output luhn_status_type      status,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [1:0]           verdict,
   output logic [4:0]           digit_count,
   output logic                 checksum_ok
);

   function automatic logic [BcdWidth-1:0] dabble_byte(input logic [BcdWidth-1:0] bcd,
                                                       input logic [7:0] bits);
      logic [BcdWidth-1:0] work;
      logic [3:0]          dig;
      work = bcd;
      for (int b = 7; b >= 0; b--) begin
         for (int i = 0; i < BcdDigits; i++) begin
            dig = work[4*i +: 4];
            if (dig >= 4'd5) begin
               work[4*i +: 4] = dig + 4'd3;
            end
         end
         work = {work[BcdWidth-2:0], bits[b]};
      end
      return work;
   endfunction

   function automatic logic [3:0] doubled_digit(input logic [3:0] d);
      logic [3:0] r;
      case (d)
         4'd0:    r = 4'd0;
         4'd1:    r = 4'd2;
         4'd2:    r = 4'd4;
         4'd3:    r = 4'd6;
         4'd4:    r = 4'd8;
         4'd5:    r = 4'd1;
         4'd6:    r = 4'd3;
         4'd7:    r = 4'd5;
         4'd8:    r = 4'd7;
         4'd9:    r = 4'd9;
         default: r = 4'd0;
      endcase
      return r;
   endfunction

   logic [BinWidth-1:0] bin_ff, bin_in;
   logic [BcdWidth-1:0] bcd_ff, bcd_in;
   logic [3:0]          acc_ff, acc_in;
   logic [4:0]          pos_ff, pos_in;
   logic [4:0]          count_ff, count_in;
   logic [3:0]          hi_ff, hi_in;
   logic [3:0]          lo_ff, lo_in;
   logic [3:0]          prev_ff, prev_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          verdict_ff, verdict_in;
   logic [4:0]          digit_count_ff, digit_count_in;
   logic                checksum_ok_ff, checksum_ok_in;

   logic [3:0] d0, d1;
   logic [4:0] pair_sum;
   logic       length_ok;
   logic       sum_ok;

   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign d0       = bcd_ff[3:0];
   assign d1       = bcd_ff[7:4];
   assign pair_sum = {1'b0, acc_ff} + {1'b0, d0} + {1'b0, doubled_digit(d1)};

   assign length_ok = (count_ff == 5'd13) || (count_ff == 5'd15) || (count_ff == 5'd16);
   assign sum_ok    = (acc_ff == 4'd0);

   always_comb begin
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      acc_in   = acc_ff;
      pos_in   = pos_ff;
      count_in = count_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      prev_in  = prev_ff;
      if (cmd.load) begin
         bin_in   = {{(BinWidth - CardWidth){1'b0}}, card_number};
         bcd_in   = '0;
         acc_in   = '0;
         pos_in   = '0;
         count_in = '0;
         hi_in    = '0;
         lo_in    = '0;
         prev_in  = '0;
      end else if (cmd.convert) begin
         bin_in = {bin_ff[BinWidth-9:0], 8'd0};
         bcd_in = dabble_byte(bcd_ff, bin_ff[BinWidth-1 -: 8]);
      end else if (cmd.scan) begin
         bcd_in = {8'd0, bcd_ff[BcdWidth-1:8]};
         if (pair_sum >= 5'd20) begin
            acc_in = 4'(pair_sum - 5'd20);
         end else if (pair_sum >= 5'd10) begin
            acc_in = 4'(pair_sum - 5'd10);
         end else begin
            acc_in = pair_sum[3:0];
         end
         if (d1 != 4'd0) begin
            count_in = pos_ff + 5'd2;
            hi_in    = d1;
            lo_in    = d0;
         end else if (d0 != 4'd0) begin
            count_in = pos_ff + 5'd1;
            hi_in    = d0;
            lo_in    = prev_ff;
         end
         prev_in = d1;
         pos_in  = pos_ff + 5'd2;
      end
   end

   always_comb begin
      verdict_in = VERDICT_INVALID;
      if (length_ok && sum_ok) begin
         if (hi_ff == 4'd5 && lo_ff >= 4'd1 && lo_ff <= 4'd5) begin
            verdict_in = VERDICT_MASTERCARD;
         end else if (hi_ff == 4'd3 && (lo_ff == 4'd4 || lo_ff == 4'd7)) begin
            verdict_in = VERDICT_AMEX;
         end else if (hi_ff == 4'd4) begin
            verdict_in = VERDICT_VISA;
         end
      end
      digit_count_in = count_ff;
      checksum_ok_in = sum_ok;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff   <= bin_in;
      bcd_ff   <= bcd_in;
      acc_ff   <= acc_in;
      pos_ff   <= pos_in;
      count_ff <= count_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      prev_ff  <= prev_in;
      if (cmd.finish) begin
         verdict_ff     <= verdict_in;
         digit_count_ff <= digit_count_in;
         checksum_ok_ff <= checksum_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign verdict     = verdict_ff;
   assign digit_count = digit_count_ff;
   assign checksum_ok = checksum_ok_ff;

endmodule

@@ src/card_number_luhn_brand_check_unit.sv @@
// Channel | Direction | Ports                        | tdata fields, lowest bit first
// req     | in        | req_tvalid/tready/tdata[55:0] | card_number[53:0], zero fill
// rsp     | out       | rsp_tvalid/tready/tdata[7:0]  | verdict[1:0], digit_count, checksum_ok
//
// One card number passes from its transfer to the result through binary to BCD
// conversion at eight bits per cycle, a digit scan at two digits per cycle, and
// a register that holds the result.
// A new number is taken in the cycle after the result is registered.
// Reset is synchronous and active high; it clears the controller and the result valid.
// A stalled result holds in its register and blocks only the next result.
module card_number_luhn_brand_check_unit
   import luhn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // card_number[53:0], zero fill [55:54]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // verdict[1:0], digit_count[6:2], checksum_ok[7]
);

   luhn_cmd_type    cmd;
   luhn_status_type status;
   logic [1:0]      verdict;
   logic [4:0]      digit_count;
   logic            checksum_ok;

   luhn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   luhn_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .card_number (req_tdata[CardWidth-1:0]),
      .cmd         (cmd),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .verdict     (verdict),
      .digit_count (digit_count),
      .checksum_ok (checksum_ok)
   );

   assign rsp_tdata = {checksum_ok, digit_count, verdict};

endmodule
